/* sv/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DTT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtt assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DTT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtt assertion failed");

`endif

/* sv/dtt_pkg.sv */
// Types and constants of the detection track table.
`default_nettype none
package dtt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int COORD_BITS  = 12;
	localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int TIME_BITS   = 32;
	localparam int HITS_BITS   = 16;
	localparam int LABEL_BITS  = 32;
	localparam int MARGIN_BITS = HITS_BITS + 1;
	localparam int MDIST_BITS  = 12;
	localparam int LIVE_BITS   = 16;
	localparam int SQ_BITS     = 2 * COORD_BITS;
	localparam int DIST_BITS   = SQ_BITS + 1;
	localparam int LIMIT_BITS  = 2 * MDIST_BITS;
	localparam int CMP_BITS    = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam int IN_RAW_BITS    = 2 * COORD_BITS + TIME_BITS;
	localparam int IN_TDATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_BITS   = LABEL_BITS + MARGIN_BITS + 1;
	localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_BITS = 2;

	localparam logic [HITS_BITS-1:0] HITS_MAX = '1;

	localparam logic [MDIST_BITS-1:0] MATCH_DISTANCE_RST = MDIST_BITS'(25);
	localparam logic [HITS_BITS-1:0]  MIN_HITS_RST       = HITS_BITS'(5);
	localparam logic [LIVE_BITS-1:0]  LIVE_TIME_RST      = LIVE_BITS'(1000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MATCH_DISTANCE = 2'd0,
		REG_MIN_HITS       = 2'd1,
		REG_LIVE_TIME      = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	// One slot of the track memory.
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [TIME_BITS-1:0]  stamp;
		logic [HITS_BITS-1:0]  hits;
		logic [LABEL_BITS-1:0] label;
	} entry_t;

	// Tag that travels beside each slot read through the distance pipeline.
	typedef struct packed {
		logic                en;
		logic [IDX_BITS-1:0] idx;
		logic                live;
	} scan_ctl_t;

	typedef struct packed {
		scan_ctl_t             ctl;
		logic [DIST_BITS-1:0]  sq_sum;
		logic [LABEL_BITS-1:0] label;
		logic [HITS_BITS-1:0]  hits;
	} dist_res_t;

endpackage
`default_nettype wire

/* sv/dtt_dist.sv */
// Squared-distance pipeline from a slot read to its distance to the detection.
`default_nettype none
module dtt_dist (
	input  wire                             clk,
	input  wire                             arst_n,
	input  dtt_pkg::scan_ctl_t              ctl_s1,
	input  dtt_pkg::entry_t                 entry_s1,
	input  wire [dtt_pkg::COORD_BITS-1:0]   px,
	input  wire [dtt_pkg::COORD_BITS-1:0]   py,
	output dtt_pkg::dist_res_t              res_s3
);

	logic [dtt_pkg::COORD_BITS-1:0] dx_d, dy_d;
	logic [dtt_pkg::COORD_BITS-1:0] dx_s2, dy_s2;
	dtt_pkg::scan_ctl_t             ctl_s2, ctl_s3;
	logic [dtt_pkg::LABEL_BITS-1:0] label_s2, label_s3;
	logic [dtt_pkg::HITS_BITS-1:0]  hits_s2, hits_s3;
	logic [dtt_pkg::SQ_BITS-1:0]    sqx_s3, sqy_s3;

	always_comb begin
		dx_d = (entry_s1.x > px) ? entry_s1.x - px : px - entry_s1.x;
		dy_d = (entry_s1.y > py) ? entry_s1.y - py : py - entry_s1.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2    <= dx_d;
		dy_s2    <= dy_d;
		label_s2 <= entry_s1.label;
		hits_s2  <= entry_s1.hits;
		sqx_s3   <= dtt_pkg::SQ_BITS'(dx_s2) * dtt_pkg::SQ_BITS'(dx_s2);
		sqy_s3   <= dtt_pkg::SQ_BITS'(dy_s2) * dtt_pkg::SQ_BITS'(dy_s2);
		label_s3 <= label_s2;
		hits_s3  <= hits_s2;
	end

	always_comb begin
		res_s3.ctl    = ctl_s3;
		res_s3.sq_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		res_s3.label  = label_s3;
		res_s3.hits   = hits_s3;
	end

endmodule
`default_nettype wire

/* sv/detection_track_table_unit.sv */
// Top level of the detection track table: slot memory, scan control, result register.
`default_nettype none
// Associates each detection with the nearest live track of a TABLE_DEPTH-slot
// table (squared pixel distance, ties to the lowest label) within the match
// distance, updating or creating the track and reporting its label, hit margin
// and confirmation, or flagging a full table. For each accepted item the single
// read port of the slot memory visits every slot once, followed by a three-stage
// distance pipeline and a write-back step. A finished result sits in the output
// register, so the next item is taken while it waits; a second result holds in
// the write-back step until the first one is taken.
// Reset needs no clearing pass; slot valid bits are flip-flops.
module detection_track_table_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// pos_x, pos_y, now_time
	input  wire [dtt_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// track_label, hit_margin, confirmed, zero pad
	output logic [dtt_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
	// is_new, table_full
	output logic [dtt_pkg::OUT_TUSER_BITS-1:0]    m_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [dtt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire [dtt_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int N  = dtt_pkg::TABLE_DEPTH;
	localparam int IW = dtt_pkg::IDX_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

	// configuration
	logic [dtt_pkg::MDIST_BITS-1:0] match_distance_q;
	logic [dtt_pkg::HITS_BITS-1:0]  min_hits_q;
	logic [dtt_pkg::LIVE_BITS-1:0]  live_time_q;
	logic [dtt_pkg::LIMIT_BITS-1:0] limit_q;

	// item and control
	dtt_pkg::state_t                state_q, state_d;
	logic [IW-1:0]                  cnt_q;
	logic [dtt_pkg::COORD_BITS-1:0] px_q, py_q;
	logic [dtt_pkg::TIME_BITS-1:0]  now_q;
	logic [N-1:0]                   slot_valid_q;
	logic [N-1:0]                   old_q;
	logic [dtt_pkg::LABEL_BITS-1:0] label_ctr_q;

	// running best and first free slot
	logic                           found_q;
	logic [dtt_pkg::DIST_BITS-1:0]  best_d_q;
	logic [dtt_pkg::LABEL_BITS-1:0] best_label_q;
	logic [dtt_pkg::HITS_BITS-1:0]  best_hits_q;
	logic [IW-1:0]                  best_idx_q;
	logic                           free_found_q;
	logic [IW-1:0]                  free_idx_q;

	// memory and pipeline
	dtt_pkg::entry_t                mem [N];
	dtt_pkg::entry_t                entry_s1;
	dtt_pkg::scan_ctl_t             ctl_s1;
	dtt_pkg::dist_res_t             res_s3;

	// output register
	logic                           out_valid_q;
	logic [dtt_pkg::OUT_TDATA_BITS-1:0] out_tdata_q;
	logic [dtt_pkg::OUT_TUSER_BITS-1:0] out_tuser_q;

	// decision logic
	logic                           in_fire;
	logic                           issue;
	logic                           better;
	logic                           aged;
	logic [dtt_pkg::TIME_BITS-1:0]  age;
	logic                           match;
	logic                           out_load;
	logic                           mem_we;
	logic [IW-1:0]                  mem_waddr;
	dtt_pkg::entry_t                mem_wdata;
	logic [dtt_pkg::HITS_BITS-1:0]  new_hits;
	logic [dtt_pkg::MARGIN_BITS-1:0] margin;
	logic [dtt_pkg::LABEL_BITS-1:0] out_label;
	logic                           out_confirmed;
	logic                           out_is_new;
	logic                           out_full;
	logic [N-1:0]                   free_mask;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == dtt_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign issue         = (state_q == dtt_pkg::ST_SCAN);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_distance_q <= dtt_pkg::MATCH_DISTANCE_RST;
			min_hits_q       <= dtt_pkg::MIN_HITS_RST;
			live_time_q      <= dtt_pkg::LIVE_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dtt_pkg::cfg_reg_t'(cfg_index))
				dtt_pkg::REG_MATCH_DISTANCE:
					match_distance_q <= cfg_data[dtt_pkg::MDIST_BITS-1:0];
				dtt_pkg::REG_MIN_HITS: min_hits_q  <= cfg_data[dtt_pkg::HITS_BITS-1:0];
				dtt_pkg::REG_LIVE_TIME: live_time_q <= cfg_data[dtt_pkg::LIVE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		limit_q <= dtt_pkg::LIMIT_BITS'(match_distance_q) *
			dtt_pkg::LIMIT_BITS'(match_distance_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtt_pkg::ST_IDLE:   if (in_fire) state_d = dtt_pkg::ST_SCAN;
			dtt_pkg::ST_SCAN:   if (cnt_q == LAST_IDX) state_d = dtt_pkg::ST_DRAIN;
			dtt_pkg::ST_DRAIN:  if (res_s3.ctl.en && res_s3.ctl.idx == LAST_IDX)
				state_d = dtt_pkg::ST_DECIDE;
			dtt_pkg::ST_DECIDE: if (!out_valid_q || m_axis_tready) state_d = dtt_pkg::ST_IDLE;
			default:            state_d = dtt_pkg::ST_IDLE;
		endcase
	end

	// per-slot scan logic
	always_comb begin
		age    = now_q - entry_s1.stamp;
		aged   = ctl_s1.en && ctl_s1.live && (age > {{(dtt_pkg::TIME_BITS -
			dtt_pkg::LIVE_BITS){1'b0}}, live_time_q});
		better = res_s3.ctl.en && res_s3.ctl.live &&
			(!found_q || res_s3.sq_sum < best_d_q ||
			(res_s3.sq_sum == best_d_q && res_s3.label < best_label_q));
	end

	// decision outputs
	always_comb begin
		match = found_q && (dtt_pkg::CMP_BITS'(best_d_q) < dtt_pkg::CMP_BITS'(limit_q));
		new_hits = (best_hits_q == dtt_pkg::HITS_MAX) ? best_hits_q
			: best_hits_q + dtt_pkg::HITS_BITS'(1);
		out_load  = (state_q == dtt_pkg::ST_DECIDE) && (!out_valid_q || m_axis_tready);
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = '{x: px_q, y: py_q, stamp: now_q, hits: new_hits, label: best_label_q};
		free_mask = '0;
		out_is_new    = 1'b0;
		out_full      = 1'b0;
		out_label     = '0;
		margin        = '0;
		out_confirmed = 1'b0;
		if (match) begin
			mem_we        = out_load;
			margin        = {1'b0, new_hits} - {1'b0, min_hits_q};
			out_label     = best_label_q;
			out_confirmed = !margin[dtt_pkg::MARGIN_BITS-1] && (margin != '0);
			free_mask     = old_q;
			// the matched track was just restamped, it cannot age out
			free_mask[best_idx_q] = 1'b0;
		end else if (free_found_q) begin
			mem_we          = out_load;
			mem_waddr       = free_idx_q;
			mem_wdata.hits  = '0;
			mem_wdata.label = label_ctr_q;
			out_is_new      = 1'b1;
			out_label       = label_ctr_q;
			margin          = dtt_pkg::MARGIN_BITS'(0) - {1'b0, min_hits_q};
		end else begin
			out_full = 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dtt_pkg::ST_IDLE;
			cnt_q        <= '0;
			slot_valid_q <= '0;
			old_q        <= '0;
			label_ctr_q  <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			ctl_s1       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ctl_s1  <= '{en: issue, idx: cnt_q, live: slot_valid_q[cnt_q]};
			if (in_fire) begin
				cnt_q        <= '0;
				old_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (issue && cnt_q != LAST_IDX) cnt_q <= cnt_q + IW'(1);
				if (aged) old_q[ctl_s1.idx] <= 1'b1;
				if (better) found_q <= 1'b1;
				if (issue && !slot_valid_q[cnt_q]) free_found_q <= 1'b1;
			end
			if (out_load) begin
				if (match) begin
					slot_valid_q <= slot_valid_q & ~free_mask;
				end else if (free_found_q) begin
					slot_valid_q[free_idx_q] <= 1'b1;
					label_ctr_q <= label_ctr_q + dtt_pkg::LABEL_BITS'(1);
				end
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_q  <= s_axis_tdata[dtt_pkg::COORD_BITS-1:0];
			py_q  <= s_axis_tdata[2*dtt_pkg::COORD_BITS-1:dtt_pkg::COORD_BITS];
			now_q <= s_axis_tdata[dtt_pkg::IN_RAW_BITS-1:2*dtt_pkg::COORD_BITS];
		end
		if (better) begin
			best_d_q     <= res_s3.sq_sum;
			best_label_q <= res_s3.label;
			best_hits_q  <= res_s3.hits;
			best_idx_q   <= res_s3.ctl.idx;
		end
		if (issue && !slot_valid_q[cnt_q] && !free_found_q) free_idx_q <= cnt_q;
		if (out_load) begin
			out_tdata_q <= dtt_pkg::OUT_TDATA_BITS'({out_confirmed, margin, out_label});
			out_tuser_q <= {out_full, out_is_new};
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		entry_s1 <= mem[cnt_q];
	end

	dtt_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.entry_s1 (entry_s1),
		.px       (px_q),
		.py       (py_q),
		.res_s3   (res_s3)
	);

endmodule
`default_nettype wire

/* sv/dtt_checker.sv */
// Port-level checks of the detection track table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module dtt_checker (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   s_axis_tvalid,
	input wire                                   s_axis_tready,
	input wire [dtt_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
	input wire [dtt_pkg::OUT_TUSER_BITS-1:0]     m_axis_tuser,
	input wire                                   m_axis_tvalid,
	input wire                                   m_axis_tready
);

	localparam int CONF_BIT = dtt_pkg::OUT_RAW_BITS - 1;

	// held result stays put until taken
	`DTT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// one item at a time: busy right after an accept
	`DTT_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`DTT_ASSERT_IMP(a_new_or_full, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
	// a dropped detection carries an all-zero payload
	`DTT_ASSERT_IMP(a_full_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0)
	`DTT_ASSERT_IMP(a_new_unconfirmed, m_axis_tvalid && m_axis_tuser[0],
		!m_axis_tdata[CONF_BIT])

endmodule

bind detection_track_table_unit dtt_checker u_dtt_checker (.*);
`default_nettype wire
